### sv/assert_macros.svh
// Assertion macros of the checker, all on clk; only ASSERT_NEXT is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, off while in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Implication into the next cycle, checked during reset too.
`define ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Condition that holds at every edge.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) (cond)) \
    else $error("assertion failed: label");

`endif

### sv/sm4_pkg.sv
// Types, constants and round functions of the SM4 cipher core.
`default_nettype none

package sm4_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int RND_W = 5;
  localparam int CNT_W = 6;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  typedef struct packed {
    logic         valid;
    logic         dec;
    logic [127:0] x;
  } sm4_link_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] x);
    subst = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] x);
    logic [31:0] b;
    b = subst(x);
    key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic logic [31:0] data_mix(input logic [31:0] x);
    logic [31:0] b;
    b = subst(x);
    data_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // byte j of CK_i is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [1:0]  jj;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      jj = 2'(j);
      w = {w[23:0], 8'({1'b0, i, jj} * 8'd7)};
    end
    ck_word = w;
  endfunction

endpackage

`default_nettype wire

### sv/sm4_key_cell.sv
// One key schedule round: slides the four-word key window by one word.
`default_nettype none

module sm4_key_cell (
  input  wire logic         clk,
  input  wire logic [127:0] window_in,
  input  wire logic [31:0]  ck,
  output logic      [127:0] window
);
  import sm4_pkg::*;

  logic [31:0] n;

  assign n = window_in[127:96] ^
             key_mix(window_in[95:64] ^ window_in[63:32] ^ window_in[31:0] ^ ck);

  always_ff @(posedge clk) begin
    window <= {window_in[95:0], n};
  end

endmodule

`default_nettype wire

### sv/sm4_round_cell.sv
// One cipher round stage with its valid bit and local flow control.
`default_nettype none

module sm4_round_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sm4_pkg::sm4_link_t link_in,
  input  wire logic [31:0]       rk_fwd,
  input  wire logic [31:0]       rk_rev,
  input  wire logic              ready_in,
  output sm4_pkg::sm4_link_t     link,
  output logic                   ready_out
);
  import sm4_pkg::*;

  logic [31:0] rk;
  logic [31:0] n;

  assign ready_out = !link.valid || ready_in;
  assign rk = link_in.dec ? rk_rev : rk_fwd;
  assign n = link_in.x[127:96] ^
             data_mix(link_in.x[95:64] ^ link_in.x[63:32] ^ link_in.x[31:0] ^ rk);

  always_ff @(posedge clk) begin
    if (rst) begin
      link.valid <= 1'b0;
    end else if (ready_out) begin
      link.valid <= link_in.valid;
    end
    if (ready_out) begin
      link.dec <= link_in.dec;
      link.x   <= {link_in.x[95:0], n};
    end
  end

endmodule

`default_nettype wire

### sv/sm4_block_cipher_core.sv
// Top level of the SM4 cipher core: key registers, key schedule chain, round chain.
`default_nettype none

// SM4 encrypt/decrypt engine. One 128-bit request enters per cycle while in_ready is
// high, and its result leaves from the last of 32 round stages; each stage holds one
// request, so a stall at the output collapses bubbles before it blocks the input.
// Round keys come from a chain of 32 key schedule stages fed from the key
// registers. After reset and after every key write, in_ready stays low while that
// chain settles; APB writes are taken at any time.
module sm4_block_cipher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [63:0] data_hi,
  input  wire logic [63:0] data_lo,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] result_hi,
  output logic      [63:0] result_lo
);
  import sm4_pkg::*;

  logic [63:0]      key_hi;
  logic [63:0]      key_lo;
  logic [CNT_W-1:0] key_cnt;
  logic             keys_ready;
  logic             cfg_write;

  logic [127:0] key_win [NUM_ROUNDS+1];
  logic [31:0]  rk [NUM_ROUNDS];

  sm4_link_t link  [NUM_ROUNDS+1];
  logic      ready [NUM_ROUNDS+1];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = paddr[3] ? key_lo : key_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        key_lo <= pwdata;
      end else begin
        key_hi <= pwdata;
      end
    end
  end

  assign keys_ready = (key_cnt == CNT_W'(NUM_ROUNDS));

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      key_cnt <= '0;
    end else if (!keys_ready) begin
      key_cnt <= key_cnt + 1'b1;
    end
  end

  assign key_win[0] = {key_hi[63:32] ^ FK0, key_hi[31:0] ^ FK1,
                       key_lo[63:32] ^ FK2, key_lo[31:0] ^ FK3};

  assign link[0].valid = in_valid && keys_ready;
  assign link[0].dec   = req_type;
  assign link[0].x     = {data_hi, data_lo};

  assign ready[NUM_ROUNDS] = out_ready;

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_rnd
    sm4_key_cell u_key (
      .clk       (clk),
      .window_in (key_win[i]),
      .ck        (ck_word(RND_W'(i))),
      .window    (key_win[i+1])
    );

    assign rk[i] = key_win[i+1][31:0];

    sm4_round_cell u_round (
      .clk       (clk),
      .rst       (rst),
      .link_in   (link[i]),
      .rk_fwd    (rk[i]),
      .rk_rev    (rk[NUM_ROUNDS-1-i]),
      .ready_in  (ready[i+1]),
      .link      (link[i+1]),
      .ready_out (ready[i])
    );
  end

  assign in_ready  = keys_ready && ready[0];
  assign out_valid = link[NUM_ROUNDS].valid;
  assign result_hi = {link[NUM_ROUNDS].x[31:0], link[NUM_ROUNDS].x[63:32]};
  assign result_lo = {link[NUM_ROUNDS].x[95:64], link[NUM_ROUNDS].x[127:96]};

endmodule

`default_nettype wire

### sv/sm4_checker.sv
// Port-level checker of the SM4 cipher core and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module sm4_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic        pready,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_hi,
  input wire logic [63:0] result_lo
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_hi) && $stable(result_lo))
  `ASSERT_NEXT(a_key_write_blocks, psel && penable && pwrite, !in_ready)
  `ASSERT_NEXT_ANY(a_reset_clears, rst, !out_valid && !in_ready)
  `ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind sm4_block_cipher_core sm4_checker u_sm4_checker (.*);

`default_nettype wire
